### hw/rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // default screen geometry
   localparam int SCREEN_WIDTH_DEF  = 80;
   localparam int SCREEN_HEIGHT_DEF = 25;

   // stream payload widths (fields packed from the lowest bit, padded to bytes)
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   // character codes
   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] BLANK_CHAR   = 8'h20;

   // a tab expands to this many blanks
   localparam logic [2:0] TAB_SPACES = 3'd4;

   // reset value of the attribute registers
   localparam logic [7:0] ATTR_RESET = 8'h07;

   // commands
   typedef enum logic [1:0] {
      CMD_PUT_CHAR   = 2'd0,
      CMD_CLEAR      = 2'd1,
      CMD_SET_CURSOR = 2'd2,
      CMD_READ_CELL  = 2'd3
   } cmd_type;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_TEXT_ATTR  = 2'd0,
      REG_FILL_ATTR  = 2'd1,
      REG_CLEAR_ATTR = 2'd2
   } reg_index_type;

endpackage

### hw/rtl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/text_console_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Character-cell screen store with a cursor: put char, clear, set cursor and
// read cell, with line wrap and scroll-up, all held in one cell RAM.
// ----------------------------------------------------------------------------
// Sequence: set cursor, newline without scroll and a zero byte go from idle
// straight to the done state; read cell passes the read state and a printed
// char the glyph state, where a tab stays for each of its blanks. A scroll
// walks the store in the scroll and fill states, a clear in the clear state.
// Flow: one request at a time; the next transfer is taken once the result
// is loaded into the output register, later while that register is held.
// Reset: synchronous; a clearing pass then zeroes all CELL_COUNT cells,
// during which no request is taken.
// ----------------------------------------------------------------------------
module text_console_writer_unit #(
   parameter int SCREEN_WIDTH  = tcw_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = tcw_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request stream
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // cmd[1:0], char_code[9:2], target_line[17:10], target_column[25:18],
   // cell_index[36:26], zero[39:37]
   input  logic [tcw_pkg::REQ_DATA_W-1:0] req_tdata,
   // response stream
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // cursor_line[5:0], cursor_column[12:6], cursor_linear[24:13],
   // cell_value[40:25], scrolled[41], accepted[42], zero[47:43]
   output logic [tcw_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // configuration write port
   input  logic                           csr_wr_en,
   input  logic [tcw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0] csr_wr_data
);

   import tcw_pkg::*;

   localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int LINE_W     = $clog2(SCREEN_HEIGHT);
   localparam int COL_W      = $clog2(SCREEN_WIDTH);

   localparam logic [ADDR_W-1:0] LAST_COPY  = ADDR_W'(CELL_COUNT - SCREEN_WIDTH - 1);
   localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_COUNT - 1);
   localparam logic [ADDR_W-1:0] ROW_STEP   = ADDR_W'(SCREEN_WIDTH);
   localparam logic [LINE_W-1:0] LAST_LINE  = LINE_W'(SCREEN_HEIGHT - 1);
   localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(SCREEN_WIDTH - 1);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_GLYPH,
      ST_SCROLL,
      ST_FILL,
      ST_CLEAR,
      ST_READ,
      ST_DONE
   } state_type;

   // request fields
   cmd_type     req_cmd;
   logic [7:0]  req_char;
   logic [7:0]  req_line;
   logic [7:0]  req_column;
   logic [10:0] req_index;

   assign req_cmd    = cmd_type'(req_tdata[1:0]);
   assign req_char   = req_tdata[9:2];
   assign req_line   = req_tdata[17:10];
   assign req_column = req_tdata[25:18];
   assign req_index  = req_tdata[36:26];

   // registers and next values
   state_type             state_ff, state_in;
   logic [LINE_W-1:0]     cur_line_ff, cur_line_in;
   logic [COL_W-1:0]      cur_column_ff, cur_column_in;
   logic [ADDR_W-1:0]     sweep_ff, sweep_in;
   logic                  pend_ff, pend_in;
   logic [ADDR_W-1:0]     pend_addr_ff, pend_addr_in;
   logic [2:0]            glyph_cnt_ff, glyph_cnt_in;
   logic [7:0]            glyph_char_ff, glyph_char_in;
   logic                  scrolled_ff, scrolled_in;
   logic                  accepted_ff, accepted_in;
   logic [15:0]           cell_ff, cell_in;
   logic [7:0]            text_attr_ff, text_attr_in;
   logic [7:0]            fill_attr_ff, fill_attr_in;
   logic [7:0]            clear_attr_ff, clear_attr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // RAM port signals
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [15:0]       ram_wr_data;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [15:0]       ram_rd_data;

   logic              req_xfer;
   logic [ADDR_W-1:0] cursor_pos;
   logic [11:0]       cursor_linear;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // cursor address in the store and as reported
   assign cursor_pos    = ADDR_W'(32'(cur_line_ff) * SCREEN_WIDTH + 32'(cur_column_ff));
   assign cursor_linear = 12'(32'(cur_line_ff) * SCREEN_WIDTH + 32'(cur_column_ff));

   tcw_ram #(
      .WIDTH (16),
      .DEPTH (CELL_COUNT)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // configuration writes
   always_comb begin
      text_attr_in  = text_attr_ff;
      fill_attr_in  = fill_attr_ff;
      clear_attr_in = clear_attr_ff;
      if (csr_wr_en) begin
         case (reg_index_type'(csr_index))
            REG_TEXT_ATTR:  text_attr_in  = csr_wr_data;
            REG_FILL_ATTR:  fill_attr_in  = csr_wr_data;
            REG_CLEAR_ATTR: clear_attr_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   // sequencer: next state, cursor and RAM accesses
   always_comb begin
      state_in      = state_ff;
      cur_line_in   = cur_line_ff;
      cur_column_in = cur_column_ff;
      sweep_in      = sweep_ff;
      pend_in       = 1'b0;
      pend_addr_in  = sweep_ff;
      glyph_cnt_in  = glyph_cnt_ff;
      glyph_char_in = glyph_char_ff;
      scrolled_in   = scrolled_ff;
      accepted_in   = accepted_ff;
      cell_in       = cell_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = sweep_ff;
      ram_wr_data   = 16'h0000;
      ram_rd_addr   = sweep_ff + ROW_STEP;

      case (state_ff)
         // clear the store after reset
         ST_INIT: begin
            ram_wr_en = 1'b1;
            sweep_in  = sweep_ff + 1'b1;
            if (sweep_ff == LAST_CELL) begin
               sweep_in = '0;
               state_in = ST_IDLE;
            end
         end

         // take a request and dispatch it
         ST_IDLE: begin
            ram_rd_addr = ADDR_W'(req_index);
            if (req_xfer) begin
               scrolled_in = 1'b0;
               accepted_in = 1'b1;
               cell_in     = 16'h0000;
               sweep_in    = '0;
               state_in    = ST_DONE;
               case (req_cmd)
                  CMD_PUT_CHAR: begin
                     if (req_char == CHAR_NEWLINE) begin
                        cur_column_in = '0;
                        if (cur_line_ff == LAST_LINE) begin
                           scrolled_in  = 1'b1;
                           glyph_cnt_in = '0;
                           state_in     = ST_SCROLL;
                        end else begin
                           cur_line_in = cur_line_ff + 1'b1;
                        end
                     end else if (req_char == CHAR_TAB) begin
                        glyph_cnt_in  = TAB_SPACES;
                        glyph_char_in = BLANK_CHAR;
                        state_in      = ST_GLYPH;
                     end else if (req_char != CHAR_NUL) begin
                        glyph_cnt_in  = 3'd1;
                        glyph_char_in = req_char;
                        state_in      = ST_GLYPH;
                     end
                  end
                  CMD_CLEAR: begin
                     state_in = ST_CLEAR;
                  end
                  CMD_SET_CURSOR: begin
                     if (32'(req_line) < SCREEN_HEIGHT && 32'(req_column) < SCREEN_WIDTH) begin
                        cur_line_in   = LINE_W'(req_line);
                        cur_column_in = COL_W'(req_column);
                     end else begin
                        accepted_in = 1'b0;
                     end
                  end
                  CMD_READ_CELL: begin
                     if (32'(req_index) < CELL_COUNT) begin
                        state_in = ST_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // print one glyph at the cursor and advance
         ST_GLYPH: begin
            ram_wr_en    = 1'b1;
            ram_wr_addr  = cursor_pos;
            ram_wr_data  = {text_attr_ff, glyph_char_ff};
            glyph_cnt_in = glyph_cnt_ff - 1'b1;
            state_in     = (glyph_cnt_ff == 3'd1) ? ST_DONE : ST_GLYPH;
            if (cur_column_ff == LAST_COL) begin
               cur_column_in = '0;
               if (cur_line_ff == LAST_LINE) begin
                  scrolled_in = 1'b1;
                  sweep_in    = '0;
                  state_in    = ST_SCROLL;
               end else begin
                  cur_line_in = cur_line_ff + 1'b1;
               end
            end else begin
               cur_column_in = cur_column_ff + 1'b1;
            end
         end

         // move every line up: read cell i+W, write it to cell i in the cycle after
         ST_SCROLL: begin
            ram_wr_en    = pend_ff;
            ram_wr_addr  = pend_addr_ff;
            ram_wr_data  = ram_rd_data;
            pend_in      = 1'b1;
            pend_addr_in = sweep_ff;
            sweep_in     = sweep_ff + 1'b1;
            if (sweep_ff == LAST_COPY) begin
               state_in = ST_FILL;
            end
         end

         // drain the last copy, then blank the bottom line
         ST_FILL: begin
            ram_wr_en = 1'b1;
            if (pend_ff) begin
               ram_wr_addr = pend_addr_ff;
               ram_wr_data = ram_rd_data;
            end else begin
               ram_wr_data = {fill_attr_ff, BLANK_CHAR};
               sweep_in    = sweep_ff + 1'b1;
               if (sweep_ff == LAST_CELL) begin
                  sweep_in = '0;
                  state_in = (glyph_cnt_ff != '0) ? ST_GLYPH : ST_DONE;
               end
            end
         end

         // blank every cell and home the cursor
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = {clear_attr_ff, BLANK_CHAR};
            sweep_in    = sweep_ff + 1'b1;
            if (sweep_ff == LAST_CELL) begin
               sweep_in      = '0;
               cur_line_in   = '0;
               cur_column_in = '0;
               state_in      = ST_DONE;
            end
         end

         // read data arrives in the cycle after the address
         ST_READ: begin
            cell_in  = ram_rd_data;
            state_in = ST_DONE;
         end

         // hand the result to the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready)) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {5'b00000, accepted_ff, scrolled_ff, cell_ff, cursor_linear,
                         7'(cur_column_ff), 6'(cur_line_ff)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         cur_line_ff   <= '0;
         cur_column_ff <= '0;
         sweep_ff      <= '0;
         pend_ff       <= 1'b0;
         glyph_cnt_ff  <= '0;
         text_attr_ff  <= ATTR_RESET;
         fill_attr_ff  <= ATTR_RESET;
         clear_attr_ff <= ATTR_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_line_ff   <= cur_line_in;
         cur_column_ff <= cur_column_in;
         sweep_ff      <= sweep_in;
         pend_ff       <= pend_in;
         glyph_cnt_ff  <= glyph_cnt_in;
         text_attr_ff  <= text_attr_in;
         fill_attr_ff  <= fill_attr_in;
         clear_attr_ff <= clear_attr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pend_addr_ff  <= pend_addr_in;
      glyph_char_ff <= glyph_char_in;
      scrolled_ff   <= scrolled_in;
      accepted_ff   <= accepted_in;
      cell_ff       <= cell_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

### dv/tb_text_console_writer_unit.sv
// ----------------------------------------------------------------------------
// tb_text_console_writer_unit
// Self-checking bench for the text console writer: drives put char, clear,
// set cursor and read cell requests over the request stream, mirrors the
// screen store and cursor in a scoreboard and compares every response.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_text_console_writer_unit;
   import tcw_pkg::*;

   localparam int SCR_W       = SCREEN_WIDTH_DEF;
   localparam int SCR_H       = SCREEN_HEIGHT_DEF;
   localparam int CELL_COUNT  = SCR_W * SCR_H;
   localparam int PHASE_ITEMS = 600;
   // slowest item: a scroll plus a tab, stalls on both sides, taken 4x over
   localparam int CYCLE_LIMIT = 4 * (3 * PHASE_ITEMS + 100) * (CELL_COUNT + 64)
                                + 4 * CELL_COUNT;
   localparam int TAIL_CYCLES = CELL_COUNT + 16;
   // index past the register list, writes to it are dropped
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 2'd3;

   // request fields, last field in the lowest bits
   typedef struct packed {
      logic [10:0] cell_index;
      logic [7:0]  target_column;
      logic [7:0]  target_line;
      logic [7:0]  char_code;
      cmd_type     cmd;
   } request_type;

   // response fields, last field in the lowest bits
   typedef struct packed {
      logic        accepted;
      logic        scrolled;
      logic [15:0] cell_value;
      logic [11:0] cursor_linear;
      logic [6:0]  cursor_column;
      logic [5:0]  cursor_line;
   } console_status_type;

   // -------------------------------------------------------------------------
   // scoreboard: shadow screen store, cursor and attributes
   // -------------------------------------------------------------------------
   class console_scoreboard;
      logic [15:0]        cells [CELL_COUNT];
      int unsigned        cur_line;
      int unsigned        cur_column;
      logic [7:0]         text_attr;
      logic [7:0]         fill_attr;
      logic [7:0]         clear_attr;
      console_status_type cursor_reports [$];
      int unsigned        error_count;

      function new();
         foreach (cells[i]) cells[i] = '0;
         cur_line    = 0;
         cur_column  = 0;
         text_attr   = ATTR_RESET;
         fill_attr   = ATTR_RESET;
         clear_attr  = ATTR_RESET;
         error_count = 0;
      endfunction

      function int pending();
         return cursor_reports.size();
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] idx, logic [7:0] value);
         case (idx)
            REG_TEXT_ATTR:  text_attr  = value;
            REG_FILL_ATTR:  fill_attr  = value;
            REG_CLEAR_ATTR: clear_attr = value;
            default: ;
         endcase
      endfunction

      // move every line up one, bottom line blank in the fill attribute
      function void scroll_up();
         for (int i = 0; i < CELL_COUNT - SCR_W; i++) cells[i] = cells[i + SCR_W];
         for (int i = CELL_COUNT - SCR_W; i < CELL_COUNT; i++)
            cells[i] = {fill_attr, BLANK_CHAR};
      endfunction

      function bit advance_line();
         cur_column = 0;
         cur_line++;
         if (cur_line >= SCR_H) begin
            cur_line = SCR_H - 1;
            scroll_up();
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function bit put_glyph(logic [7:0] ch);
         cells[cur_line * SCR_W + cur_column] = {text_attr, ch};
         cur_column++;
         if (cur_column >= SCR_W) return advance_line();
         return 1'b0;
      endfunction

      // update the shadow state for one accepted request
      function void note_request(request_type rq);
         console_status_type st;
         bit                 scr;
         bit                 acc;
         logic [15:0]        cell_word;
         scr       = 1'b0;
         acc       = 1'b1;
         cell_word = '0;
         case (rq.cmd)
            CMD_PUT_CHAR: begin
               if (rq.char_code == CHAR_NEWLINE) begin
                  scr = advance_line();
               end else if (rq.char_code == CHAR_TAB) begin
                  for (int i = 0; i < TAB_SPACES; i++)
                     if (put_glyph(BLANK_CHAR)) scr = 1'b1;
               end else if (rq.char_code != CHAR_NUL) begin
                  scr = put_glyph(rq.char_code);
               end
            end
            CMD_CLEAR: begin
               foreach (cells[i]) cells[i] = {clear_attr, BLANK_CHAR};
               cur_line   = 0;
               cur_column = 0;
            end
            CMD_SET_CURSOR: begin
               if (rq.target_line >= SCR_H || rq.target_column >= SCR_W) begin
                  acc = 1'b0;
               end else begin
                  cur_line   = rq.target_line;
                  cur_column = rq.target_column;
               end
            end
            default: begin
               if (rq.cell_index < CELL_COUNT) cell_word = cells[rq.cell_index];
            end
         endcase
         st.cursor_line   = 6'(cur_line);
         st.cursor_column = 7'(cur_column);
         st.cursor_linear = 12'(cur_line * SCR_W + cur_column);
         st.cell_value    = cell_word;
         st.scrolled      = scr;
         st.accepted      = acc;
         cursor_reports.push_back(st);
      endfunction

      task report_mismatch(string what, longint unsigned got, longint unsigned want);
         $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h",
                  $time, what, got, want);
         error_count++;
      endtask

      task check_response(console_status_type got);
         console_status_type want;
         if (cursor_reports.size() == 0) begin
            report_mismatch("unexpected response", got, 0);
         end else begin
            want = cursor_reports.pop_front();
            if (got.cursor_line !== want.cursor_line)
               report_mismatch("cursor_line", got.cursor_line, want.cursor_line);
            if (got.cursor_column !== want.cursor_column)
               report_mismatch("cursor_column", got.cursor_column, want.cursor_column);
            if (got.cursor_linear !== want.cursor_linear)
               report_mismatch("cursor_linear", got.cursor_linear, want.cursor_linear);
            if (got.cell_value !== want.cell_value)
               report_mismatch("cell_value", got.cell_value, want.cell_value);
            if (got.scrolled !== want.scrolled)
               report_mismatch("scrolled", got.scrolled, want.scrolled);
            if (got.accepted !== want.accepted)
               report_mismatch("accepted", got.accepted, want.accepted);
         end
      endtask
   endclass

   // -------------------------------------------------------------------------
   // clock, DUT signals and instance
   // -------------------------------------------------------------------------
   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata   = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_wr_en   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_wr_data = '0;

   console_scoreboard sb;
   int unsigned       req_idle_pct = 0;
   int unsigned       rsp_idle_pct = 0;
   int unsigned       cycle_count  = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   text_console_writer_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // response side: random back-pressure, check each transfer
   always @(negedge clock) rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata[42:0]);
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // stimulus helpers
   // -------------------------------------------------------------------------
   function automatic request_type make_request(cmd_type cmd, logic [7:0] ch,
                                                logic [7:0] tl, logic [7:0] tc,
                                                logic [10:0] idx);
      request_type rq;
      rq.cmd           = cmd;
      rq.char_code     = ch;
      rq.target_line   = tl;
      rq.target_column = tc;
      rq.cell_index    = idx;
      return rq;
   endfunction

   // random request, unused fields left random
   function automatic request_type random_request();
      logic [63:0] raw;
      request_type rq;
      int unsigned pick;
      raw  = {$urandom(), $urandom()};
      rq   = raw[36:0];
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         rq.cmd = CMD_CLEAR;
      end else if (pick < 22) begin
         rq.cmd = CMD_SET_CURSOR;
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            rq.target_line   = 8'($urandom_range(0, SCR_H - 1));
            rq.target_column = 8'($urandom_range(0, SCR_W - 1));
         end else if (pick < 8) begin
            // near the end of the last line, so wraps scroll
            rq.target_line   = 8'(SCR_H - 1);
            rq.target_column = 8'($urandom_range(SCR_W - 6, SCR_W - 1));
         end
      end else if (pick < 45) begin
         rq.cmd = CMD_READ_CELL;
         if ($urandom_range(0, 9) != 0) rq.cell_index = 11'($urandom_range(0, CELL_COUNT - 1));
      end else begin
         rq.cmd = CMD_PUT_CHAR;
         pick = $urandom_range(0, 99);
         if (pick < 8)       rq.char_code = CHAR_NEWLINE;
         else if (pick < 16) rq.char_code = CHAR_TAB;
         else if (pick < 19) rq.char_code = CHAR_NUL;
         else if (pick < 60) rq.char_code = 8'($urandom_range(8'h21, 8'h7E));
      end
      return rq;
   endfunction

   // one request transfer; called and returns at a falling edge
   task automatic send_request(request_type rq);
      while (req_idle_pct > 0 && $urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, rq};
      do @(posedge clock); while (!req_tready);
      sb.note_request(rq);
      @(negedge clock);
   endtask

   // hold off requests until every response is back
   task automatic wait_console_idle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // drain, then write all attribute registers plus the unused index
   task automatic write_attributes(logic [7:0] text_v, logic [7:0] fill_v,
                                   logic [7:0] clear_v);
      logic [CSR_INDEX_W-1:0] idx [4];
      logic [7:0]             val [4];
      idx = '{REG_TEXT_ATTR, REG_FILL_ATTR, REG_CLEAR_ATTR, REG_UNUSED};
      val = '{text_v, fill_v, clear_v, 8'($urandom())};
      wait_console_idle();
      repeat (8) @(negedge clock);
      for (int i = 0; i < 4; i++) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= idx[i];
         csr_wr_data <= val[i];
         sb.set_register(idx[i], val[i]);
         @(negedge clock);
      end
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_random_phase(int unsigned req_pct, int unsigned rsp_pct);
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         // sender holds off once per phase until the block is drained
         if (i == PHASE_ITEMS / 2) wait_console_idle();
         send_request(random_request());
      end
   endtask

   // -------------------------------------------------------------------------
   // main sequence
   // -------------------------------------------------------------------------
   initial begin
      sb = new();
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: store after reset, byte extremes, wrap, scroll, tab, clear
      send_request(make_request(CMD_READ_CELL, 0, 0, 0, 0));
      send_request(make_request(CMD_READ_CELL, 0, 0, 0, 11'(CELL_COUNT - 1)));
      send_request(make_request(CMD_READ_CELL, 0, 0, 0, 11'(CELL_COUNT)));
      send_request(make_request(CMD_READ_CELL, 0, 0, 0, 11'h7FF));
      send_request(make_request(CMD_PUT_CHAR, 8'h41, 0, 0, 0));
      send_request(make_request(CMD_PUT_CHAR, 8'hFF, 0, 0, 0));
      send_request(make_request(CMD_PUT_CHAR, 8'h80, 0, 0, 0));
      send_request(make_request(CMD_PUT_CHAR, CHAR_NUL, 0, 0, 0));
      send_request(make_request(CMD_PUT_CHAR, CHAR_TAB, 0, 0, 0));
      send_request(make_request(CMD_PUT_CHAR, CHAR_NEWLINE, 0, 0, 0));
      send_request(make_request(CMD_READ_CELL, 0, 0, 0, 11'd1));
      send_request(make_request(CMD_SET_CURSOR, 0, 8'(SCR_H - 1), 8'(SCR_W - 1), 0));
      send_request(make_request(CMD_PUT_CHAR, 8'h5A, 0, 0, 0));
      send_request(make_request(CMD_READ_CELL, 0, 0, 0, 11'(CELL_COUNT - SCR_W - 1)));
      send_request(make_request(CMD_SET_CURSOR, 0, 8'(SCR_H), 0, 0));
      send_request(make_request(CMD_SET_CURSOR, 0, 0, 8'(SCR_W), 0));
      send_request(make_request(CMD_SET_CURSOR, 0, 8'hFF, 8'hFF, 0));
      send_request(make_request(CMD_SET_CURSOR, 0, 8'(SCR_H - 1), 8'(SCR_W - 2), 0));
      send_request(make_request(CMD_PUT_CHAR, CHAR_TAB, 0, 0, 0));
      send_request(make_request(CMD_PUT_CHAR, CHAR_NEWLINE, 0, 0, 0));
      send_request(make_request(CMD_CLEAR, 0, 0, 0, 0));
      send_request(make_request(CMD_READ_CELL, 0, 0, 0, 11'(CELL_COUNT - 1)));
      send_request(make_request(CMD_SET_CURSOR, 0, 0, 0, 0));
      send_request(make_request(CMD_PUT_CHAR, 8'h7F, 0, 0, 0));

      // random phases with different attribute settings and idling mixes
      write_attributes(8'($urandom_range(1, 254)), 8'h00, 8'hFF);
      run_random_phase(29, 45);
      write_attributes(8'h00, 8'hFF, 8'($urandom()));
      run_random_phase(45, 29);
      write_attributes(8'hFF, 8'($urandom()), 8'h00);
      run_random_phase(0, 0);

      // drain and let the block settle
      wait_console_idle();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
